[hw/rtl/srbp_pkg.sv]
package srbp_pkg;

    // default configuration
    localparam int DEF_NUM_SETS  = 2048;
    localparam int DEF_NUM_WAYS  = 16;
    localparam int DEF_SIG_WIDTH = 5;

    // fixed field geometry
    localparam int BLK_ADDR_W  = 58;
    localparam int BLK_SHIFT   = 6;
    localparam int PC_SHIFT_A  = 7;
    localparam int PC_SHIFT_B  = 13;
    localparam logic [1:0] PRED_MAX  = 2'd3;
    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_INIT  = 2'd1;
    localparam logic [1:0] CTR_NEAR  = 2'd2;

    // request kinds
    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // access kind that weakens the evicted signature
    localparam logic [1:0] ACC_WEAKEN = 2'd0;

    typedef struct packed {
        logic        req_type;
        logic [10:0] set_index;
        logic [3:0]  way_index;
        logic [63:0] phys_addr;
        logic [63:0] pc;
        logic [1:0]  access_type;
        logic        hit;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       inserted_near;
        logic       bypassed;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_EXEC,
        S_WEAK
    } state_t;

endpackage

[hw/rtl/srbp_row_logic.sv]
module srbp_row_logic
    import srbp_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS
)
(
    input  logic [NUM_WAYS-1:0][1:0]            preds,
    output logic [$clog2(NUM_WAYS)-1:0]         victim,
    output logic [NUM_WAYS-1:0][1:0]            preds_aged
);

    localparam int WAY_W = $clog2(NUM_WAYS);

    logic             found3;
    logic             found2;
    logic [WAY_W-1:0] way3;
    logic [WAY_W-1:0] way2;

    // first way predicted distant, and first way that becomes distant after aging
    always_comb
    begin
        found3 = 1'b0;
        found2 = 1'b0;
        way3   = '0;
        way2   = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (preds[w] == PRED_MAX)
            begin
                found3 = 1'b1;
                way3   = WAY_W'(w);
            end
            if (preds[w][1])
            begin
                found2 = 1'b1;
                way2   = WAY_W'(w);
            end
        end
    end

    // age the whole set only when nothing is distant
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found3 && preds[w] != PRED_MAX)
                preds_aged[w] = preds[w] + 2'd1;
            else
                preds_aged[w] = preds[w];
        end
        if (found3)
            victim = way3;
        else if (found2)
            victim = way2;
        else
            victim = '0;
    end

endmodule

[hw/rtl/ship_rrip_stream_bypass_policy.sv]
// Replacement policy for a set-associative cache: SRRIP victim choice with
// signature-based insertion and a per-set streaming bypass. Every request
// gives one result word. A request goes through set index reduction, set row
// read, and update and write-back; an update that misses with access_type 0
// and is not bypassed also reads and weakens the signature counter
// of the replaced line, since the counter table has one read port. Set rows
// (predictions, signatures, stream counter, last block address) live in one
// memory of NUM_SETS rows; signature counters in a second memory. After
// reset a clearing pass over max(NUM_SETS, 2**SIG_WIDTH) entries runs with
// req_stall high. A result word still stalled at the output holds off the
// next request word.
module ship_rrip_stream_bypass_policy
    import srbp_pkg::*;
#(
    parameter int NUM_SETS  = DEF_NUM_SETS,
    parameter int NUM_WAYS  = DEF_NUM_WAYS,
    parameter int SIG_WIDTH = DEF_SIG_WIDTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int NUM_SIGS  = 1 << SIG_WIDTH;
    localparam int NUM_CLR   = (NUM_SETS > NUM_SIGS) ? NUM_SETS : NUM_SIGS;
    localparam int CLR_W     = $clog2(NUM_CLR);
    localparam int SIGS_W    = NUM_WAYS * SIG_WIDTH;
    localparam int PREDS_W   = NUM_WAYS * 2;
    localparam int LAST_LO   = SIGS_W + PREDS_W;
    localparam int CTR_LO    = LAST_LO + BLK_ADDR_W;
    localparam int ROW_W     = CTR_LO + 2;
    localparam int RECIP_SH  = 22;
    localparam int SET_RECIP = (1 << RECIP_SH) / NUM_SETS;

    // way index reduction, a 16-entry table
    function automatic logic [WAY_W-1:0] way_mod(input logic [3:0] w);
        logic [WAY_W-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (w == 4'(i))
                r = WAY_W'(i % NUM_WAYS);
        end
        return r;
    endfunction

    function automatic logic [SIG_WIDTH-1:0] pc_sig(input logic [63:0] pc);
        logic [63:0] x;
        x = pc ^ (pc >> PC_SHIFT_A) ^ (pc >> PC_SHIFT_B);
        return x[SIG_WIDTH-1:0];
    endfunction

    state_t                 state_reg, state_next;
    logic [CLR_W-1:0]       clr_idx_reg;
    req_t                   item_reg;
    logic [11:0]            quot_reg;
    logic [SIG_WIDTH-1:0]   sig_reg;
    logic [WAY_W-1:0]       way_reg;
    logic [SET_W-1:0]       set_reg;
    logic [SIG_WIDTH-1:0]   old_sig_reg;
    logic [ROW_W-1:0]       row_rd_reg;
    logic [1:0]             sctr_rd_reg;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;

    logic [ROW_W-1:0]       row_mem [NUM_SETS];
    logic [1:0]             sctr_mem [NUM_SIGS];

    logic                   accept;
    logic [33:0]            quot_prod;
    logic [28:0]            quot_back;
    logic [16:0]            rem_raw;
    logic [16:0]            rem;
    logic [SET_W-1:0]       set_cur;

    logic                   row_we;
    logic [SET_W-1:0]       row_wa;
    logic [ROW_W-1:0]       row_wd;
    logic                   sctr_we;
    logic [SIG_WIDTH-1:0]   sctr_wa;
    logic [1:0]             sctr_wd;
    logic [SIG_WIDTH-1:0]   sctr_ra;

    logic [1:0]                       ctr_cur;
    logic [BLK_ADDR_W-1:0]            last_cur;
    logic [NUM_WAYS-1:0][1:0]         preds_cur;
    logic [NUM_WAYS-1:0][SIG_WIDTH-1:0] sigs_cur;
    logic [NUM_WAYS-1:0][1:0]         preds_aged;
    logic [WAY_W-1:0]                 victim;

    logic [BLK_ADDR_W-1:0]            blk;
    logic                             near_seq;
    logic [1:0]                       ctr_new;
    logic [NUM_WAYS-1:0][1:0]         preds_new;
    logic [NUM_WAYS-1:0][SIG_WIDTH-1:0] sigs_new;
    logic [SIG_WIDTH-1:0]             old_sig;
    logic                             is_near;
    logic                             is_bypass;
    logic                             weaken;
    logic                             clr_row;
    logic                             clr_sig;
    rsp_t                             rsp_new;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // set index reduction: reciprocal estimate, then one correction
    assign quot_prod = 34'(req.set_index) * 34'(SET_RECIP);
    assign quot_back = 29'(quot_reg) * 29'(NUM_SETS);
    assign rem_raw   = 17'(item_reg.set_index) - quot_back[16:0];
    assign rem       = (rem_raw >= 17'(NUM_SETS)) ? rem_raw - 17'(NUM_SETS) : rem_raw;
    assign set_cur   = rem[SET_W-1:0];

    // unpack the set row
    assign ctr_cur   = row_rd_reg[CTR_LO +: 2];
    assign last_cur  = row_rd_reg[LAST_LO +: BLK_ADDR_W];
    assign preds_cur = row_rd_reg[SIGS_W +: PREDS_W];
    assign sigs_cur  = row_rd_reg[0 +: SIGS_W];

    srbp_row_logic #(
        .NUM_WAYS (NUM_WAYS)
    ) u_row (
        .preds      (preds_cur),
        .victim     (victim),
        .preds_aged (preds_aged)
    );

    assign clr_row = ({1'b0, clr_idx_reg} < (CLR_W + 1)'(NUM_SETS));
    assign clr_sig = ({1'b0, clr_idx_reg} < (CLR_W + 1)'(NUM_SIGS));

    // stream detection and row update; one extra bit keeps +1 from wrapping
    always_comb
    begin
        blk       = item_reg.phys_addr[63:BLK_SHIFT];
        near_seq  = (blk == last_cur) ||
                    ({1'b0, blk} == {1'b0, last_cur} + 59'd1) ||
                    ({1'b0, last_cur} == {1'b0, blk} + 59'd1);
        ctr_new   = ctr_cur;
        if (last_cur != '0)
        begin
            if (near_seq)
            begin
                if (ctr_cur != CTR_MAX)
                    ctr_new = ctr_cur + 2'd1;
            end
            else if (ctr_cur != 2'd0)
            begin
                ctr_new = ctr_cur - 2'd1;
            end
        end
        old_sig   = sigs_cur[way_reg];
        preds_new = preds_cur;
        sigs_new  = sigs_cur;
        is_near   = 1'b0;
        is_bypass = 1'b0;
        weaken    = 1'b0;
        if (item_reg.req_type == REQ_VICTIM)
        begin
            preds_new = preds_aged;
        end
        else if (item_reg.hit)
        begin
            preds_new[way_reg] = 2'd0;
        end
        else if (ctr_new == CTR_MAX)
        begin
            preds_new[way_reg] = PRED_MAX;
            sigs_new[way_reg]  = sig_reg;
            is_bypass          = 1'b1;
        end
        else
        begin
            is_near            = (sctr_rd_reg >= CTR_NEAR);
            preds_new[way_reg] = is_near ? 2'd0 : PRED_MAX;
            sigs_new[way_reg]  = sig_reg;
            weaken             = (item_reg.access_type == ACC_WEAKEN);
        end
        rsp_new.victim_way    = (item_reg.req_type == REQ_VICTIM) ? 4'(victim) : 4'd0;
        rsp_new.inserted_near = is_near;
        rsp_new.bypassed      = is_bypass;
    end

    // memory port control
    always_comb
    begin
        row_we  = 1'b0;
        row_wa  = set_reg;
        row_wd  = '0;
        sctr_we = 1'b0;
        sctr_wa = sig_reg;
        sctr_wd = CTR_INIT;
        sctr_ra = (state_reg == S_EXEC) ? old_sig : sig_reg;
        case (state_reg)
            S_CLEAR:
            begin
                row_we = clr_row;
                row_wa = clr_idx_reg[SET_W-1:0];
                for (int w = 0; w < NUM_WAYS; w++)
                    row_wd[SIGS_W + 2*w +: 2] = PRED_MAX;
                sctr_we = clr_sig;
                sctr_wa = clr_idx_reg[SIG_WIDTH-1:0];
                sctr_wd = CTR_INIT;
            end
            S_EXEC:
            begin
                row_we = 1'b1;
                if (item_reg.req_type == REQ_VICTIM)
                    row_wd = {ctr_cur, last_cur, preds_new, sigs_new};
                else
                    row_wd = {ctr_new, blk, preds_new, sigs_new};
                sctr_we = (item_reg.req_type == REQ_UPDATE) && item_reg.hit &&
                          (sctr_rd_reg != CTR_MAX);
                sctr_wa = sig_reg;
                sctr_wd = sctr_rd_reg + 2'd1;
            end
            S_WEAK:
            begin
                sctr_we = (sctr_rd_reg != 2'd0);
                sctr_wa = old_sig_reg;
                sctr_wd = sctr_rd_reg - 2'd1;
            end
            default:
            begin
                row_we  = 1'b0;
                sctr_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_idx_reg == CLR_W'(NUM_CLR - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (accept)
                    state_next = S_INDEX;
            S_INDEX:
                state_next = S_EXEC;
            S_EXEC:
                state_next = weaken ? S_WEAK : S_IDLE;
            S_WEAK:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (state_reg == S_EXEC)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            quot_reg <= quot_prod[RECIP_SH +: 12];
            sig_reg  <= pc_sig(req.pc);
            way_reg  <= way_mod(req.way_index);
        end
        if (state_reg == S_INDEX)
            set_reg <= set_cur;
        if (state_reg == S_EXEC)
        begin
            old_sig_reg <= old_sig;
            rsp_reg     <= rsp_new;
        end
    end

    // set row memory
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_wa] <= row_wd;
        row_rd_reg <= row_mem[set_cur];
    end

    // signature counter memory
    always_ff @(posedge clk)
    begin
        if (sctr_we)
            sctr_mem[sctr_wa] <= sctr_wd;
        sctr_rd_reg <= sctr_mem[sctr_ra];
    end

endmodule

[hw/rtl/srbp_checker.sv]
module srbp_checker
    import srbp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a miss is either bypassed or inserted, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.inserted_near && rsp.bypassed))
        else $error("near insert and bypass together");

    // a nonzero victim only comes from a victim request, which flags nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.victim_way != 4'd0) |-> !(rsp.inserted_near || rsp.bypassed))
        else $error("victim word carries update flags");

    // one request at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while previous in flight");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result word changed");

endmodule

bind ship_rrip_stream_bypass_policy srbp_checker u_srbp_checker (.*);
